// ===== hdl/dfia_pkg.sv =====
package dfia_pkg;

  // Field widths
  localparam int IDX_W      = 11;
  localparam int LIMIT_W    = 12;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 16;

  localparam int POOL_SIZE_DEF  = 2048;
  localparam int INDEX_SPACE    = 2048;
  localparam int LIMIT_RESET    = 2048;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_PENDING_FULL = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [STATUS_W-1:0] status_t;

endpackage

// ===== hdl/deferred_free_index_allocator.sv =====
// Slot index allocator with deferred free. Commands arrive on the s_ stream
// (s_tuser = command, s_tdata = slot index) and each gives exactly one result
// transfer on the m_ stream (granted index and status). An alloc served by
// the bump counter, a free and an unused command go straight to the output
// register; an alloc that pops the free stack takes its result from the
// free-stack memory in the S_POP state; a flush walks the pending-stack
// memory one entry a cycle into the free-stack memory. Its result is offered
// at the start of the walk, and no command is taken until the walk ends. A
// single output register holds each result; the next command is taken once
// it is empty or in the cycle its result leaves. Both stacks live in RAM with
// no reset and no clearing pass; only the counts are cleared. The user must
// write index_limit on the cfg channel only while the block is idle; the
// block itself does not enforce it. index_limit caps fresh indices together
// with POOL_SIZE and 2048.
module deferred_free_index_allocator #(
  parameter int POOL_SIZE = dfia_pkg::POOL_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata: slot_index[10:0], zero fill above
  input  logic [dfia_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: command[1:0]
  input  logic [dfia_pkg::CMD_W-1:0]       s_tuser,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // m_tdata: granted_index[10:0], status[12:11], zero fill above
  output logic [dfia_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [dfia_pkg::LIMIT_W-1:0]     cfg_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);

  localparam int AW = $clog2(POOL_SIZE);
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam int LimCap = (POOL_SIZE < dfia_pkg::INDEX_SPACE) ? POOL_SIZE
                                                              : dfia_pkg::INDEX_SPACE;
  localparam logic [CW-1:0] POOL_CNT = CW'(POOL_SIZE);
  localparam logic [dfia_pkg::LIMIT_W-1:0] LIM_CAP = dfia_pkg::LIMIT_W'(LimCap);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]                    state;
  logic [CW-1:0]                 free_count;
  logic [CW-1:0]                 pend_count;
  logic [dfia_pkg::LIMIT_W-1:0]  next_fresh;
  logic [dfia_pkg::LIMIT_W-1:0]  index_limit;
  logic [CW-1:0]                 flush_idx;
  logic                          flush_wr;
  logic                          out_valid;
  dfia_pkg::idx_t                out_grant;
  dfia_pkg::status_t             out_status;

  logic                          accept;
  logic [dfia_pkg::CMD_W-1:0]    cmd;
  logic [dfia_pkg::LIMIT_W-1:0]  eff_limit;
  logic [CW-1:0]                 free_dec;
  logic                          free_has;
  logic                          free_room;
  logic                          pend_room;
  logic                          flush_more;

  logic                          fs_we, fs_re;
  logic [AW-1:0]                 fs_waddr, fs_raddr;
  dfia_pkg::idx_t                fs_rdata;
  logic                          ps_we, ps_re;
  logic [AW-1:0]                 ps_waddr, ps_raddr;
  dfia_pkg::idx_t                ps_rdata;

  assign cmd        = s_tuser;
  assign s_tready   = (state == S_IDLE) && (!out_valid || m_tready);
  assign accept     = s_tvalid && s_tready;
  assign cfg_ready  = 1'b1;
  assign m_tvalid   = out_valid;
  assign m_tdata    = {{(dfia_pkg::M_TDATA_W - dfia_pkg::IDX_W - dfia_pkg::STATUS_W){1'b0}},
                       out_status, out_grant};

  assign eff_limit  = (index_limit > LIM_CAP) ? LIM_CAP : index_limit;
  assign free_dec   = free_count - CW'(1);
  assign free_has   = (free_count != '0);
  assign free_room  = (free_count < POOL_CNT);
  assign pend_room  = (pend_count < POOL_CNT);
  assign flush_more = (flush_idx < pend_count);

  // Free stack: popped by alloc, filled by the flush walk (never in the same cycle)
  assign fs_re    = accept && (cmd == dfia_pkg::CMD_ALLOC) && free_has;
  assign fs_raddr = free_dec[AW-1:0];
  assign fs_we    = (state == S_FLUSH) && flush_wr && free_room;
  assign fs_waddr = free_count[AW-1:0];

  // Pending stack: pushed by free, read in push order by the flush walk
  assign ps_we    = accept && (cmd == dfia_pkg::CMD_FREE) && pend_room;
  assign ps_waddr = pend_count[AW-1:0];
  assign ps_re    = (state == S_FLUSH) && flush_more;
  assign ps_raddr = flush_idx[AW-1:0];

  dfia_ram #(.WIDTH(dfia_pkg::IDX_W), .DEPTH(POOL_SIZE)) u_free_ram (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (ps_rdata),
    .re    (fs_re),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  dfia_ram #(.WIDTH(dfia_pkg::IDX_W), .DEPTH(POOL_SIZE)) u_pend_ram (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (s_tdata[dfia_pkg::IDX_W-1:0]),
    .re    (ps_re),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_count  <= '0;
      pend_count  <= '0;
      next_fresh  <= '0;
      index_limit <= dfia_pkg::LIMIT_W'(dfia_pkg::LIMIT_RESET);
      flush_idx   <= '0;
      flush_wr    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        index_limit <= cfg_data;
      end
      // a stack pop sets its result valid from the S_POP state, not at the transfer
      if ((accept && !fs_re) || (state == S_POP)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              dfia_pkg::CMD_ALLOC: begin
                if (free_has) begin
                  // result comes from the RAM next cycle
                  free_count <= free_dec;
                  state      <= S_POP;
                end else if (next_fresh < eff_limit) begin
                  out_grant  <= next_fresh[dfia_pkg::IDX_W-1:0];
                  out_status <= dfia_pkg::STAT_OK;
                  next_fresh <= next_fresh + dfia_pkg::LIMIT_W'(1);
                end else begin
                  out_grant  <= '0;
                  out_status <= dfia_pkg::STAT_EXHAUSTED;
                end
              end
              dfia_pkg::CMD_FREE: begin
                out_grant <= '0;
                if (pend_room) begin
                  pend_count <= pend_count + CW'(1);
                  out_status <= dfia_pkg::STAT_OK;
                end else begin
                  out_status <= dfia_pkg::STAT_PENDING_FULL;
                end
              end
              dfia_pkg::CMD_FLUSH: begin
                out_grant  <= '0;
                out_status <= dfia_pkg::STAT_OK;
                flush_idx  <= '0;
                flush_wr   <= 1'b0;
                state      <= S_FLUSH;
              end
              default: begin
                out_grant  <= '0;
                out_status <= dfia_pkg::STAT_OK;
              end
            endcase
          end
        end
        S_POP: begin
          out_grant  <= fs_rdata;
          out_status <= dfia_pkg::STAT_OK;
          state      <= S_IDLE;
        end
        S_FLUSH: begin
          // read pending entry, write it to the free stack in the next cycle if it has room
          flush_wr <= flush_more;
          if (flush_more) begin
            flush_idx <= flush_idx + CW'(1);
          end
          if (fs_we) begin
            free_count <= free_count + CW'(1);
          end
          if (!flush_more && !flush_wr) begin
            pend_count <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/dfia_ram.sv =====
module dfia_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dfia_checker.sv =====
module dfia_checker (
  input logic                            clk,
  input logic                            rst,
  input logic [dfia_pkg::S_TDATA_W-1:0]  s_tdata,
  input logic [dfia_pkg::CMD_W-1:0]      s_tuser,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [dfia_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [dfia_pkg::LIMIT_W-1:0]    cfg_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  localparam int SLO = dfia_pkg::IDX_W;
  localparam int SHI = dfia_pkg::IDX_W + dfia_pkg::STATUS_W - 1;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[SHI:SLO] == dfia_pkg::STAT_OK ||
                  m_tdata[SHI:SLO] == dfia_pkg::STAT_EXHAUSTED ||
                  m_tdata[SHI:SLO] == dfia_pkg::STAT_PENDING_FULL))
    else $error("unknown status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[SHI:SLO] != dfia_pkg::STAT_OK) |-> (m_tdata[SLO-1:0] == '0))
    else $error("error result carries a granted index");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered straight after reset");

endmodule

bind deferred_free_index_allocator dfia_checker u_dfia_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dfia_pkg::*;

  localparam int POOL = POOL_SIZE_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AT_ITEM = 120;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    idx_t             slot;
  } slot_cmd_t;

  typedef struct packed {
    idx_t    grant;
    status_t status;
  } alloc_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0]     s_tuser = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;

  deferred_free_index_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow of the allocator state
  idx_t               free_stk [POOL];
  idx_t               pend_stk [POOL];
  int                 free_cnt = 0;
  int                 pend_cnt = 0;
  int                 fresh_next = 0;
  logic [LIMIT_W-1:0] limit_cfg = LIMIT_RESET;
  int                 walk_len = 0;

  slot_cmd_t     cmd_q[$];
  alloc_result_t alloc_results_q[$];

  int err_cnt = 0;
  int items_sent = 0;
  int cycle_cnt = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  bit quiet = 1'b0;
  int quiet_left = 100;

  function automatic alloc_result_t predict_allocator(logic [CMD_W-1:0] cmd, idx_t slot);
    alloc_result_t r;
    int lim;
    int i;
    r.grant = '0;
    r.status = STAT_OK;
    lim = (int'(limit_cfg) > POOL) ? POOL : int'(limit_cfg);
    if (lim > INDEX_SPACE) lim = INDEX_SPACE;
    case (cmd)
      CMD_ALLOC: begin
        if (free_cnt > 0) begin
          free_cnt--;
          r.grant = free_stk[free_cnt];
        end else if (fresh_next < lim) begin
          r.grant = idx_t'(fresh_next);
          fresh_next++;
        end else begin
          r.status = STAT_EXHAUSTED;
        end
      end
      CMD_FREE: begin
        if (pend_cnt < POOL) begin
          pend_stk[pend_cnt] = slot;
          pend_cnt++;
        end else begin
          r.status = STAT_PENDING_FULL;
        end
      end
      CMD_FLUSH: begin
        walk_len = pend_cnt;
        // entries beyond a full free stack are lost
        for (i = 0; i < pend_cnt; i++) begin
          if (free_cnt < POOL) begin
            free_stk[free_cnt] = pend_stk[i];
            free_cnt++;
          end
        end
        pend_cnt = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    err_cnt++;
    if (err_cnt <= 200) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Driver: one transfer per queued command, random gap after each
  always @(posedge clk) begin
    slot_cmd_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        alloc_results_q.insert(alloc_results_q.size(),
                               predict_allocator(s_tuser, s_tdata[IDX_W-1:0]));
        items_sent <= items_sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          item = cmd_q.pop_front();
          s_tuser <= item.cmd;
          s_tdata <= {{(S_TDATA_W - IDX_W){1'b0}}, item.slot};
          s_tvalid <= 1'b1;
          tx_gap <= quiet ? 0 : $urandom_range(0, 15);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    alloc_result_t exp_r;
    int w;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (alloc_results_q.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          exp_r = alloc_results_q.pop_front();
          if (m_tdata[IDX_W-1:0] !== exp_r.grant)
            report_mismatch($sformatf("granted_index %0d, want %0d",
                                      m_tdata[IDX_W-1:0], exp_r.grant));
          if (m_tdata[IDX_W +: STATUS_W] !== exp_r.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      m_tdata[IDX_W +: STATUS_W], exp_r.status));
        end
        w = quiet ? 0 : $urandom_range(0, 15);
        rx_wait <= w;
        m_tready <= (w == 0) && (hold_left == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        m_tready <= (rx_wait == 1) && (hold_left == 0);
      end else begin
        m_tready <= (hold_left == 0);
      end
    end
  end

  // Long receiver hold-off once, and toggling stretches without idling
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else begin
      if (!held_once && items_sent == HOLD_AT_ITEM) begin
        hold_left <= HOLD_CYCLES;
        held_once <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      if (quiet_left == 0) begin
        quiet <= ~quiet;
        quiet_left <= $urandom_range(50, 300);
      end else begin
        quiet_left <= quiet_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, idx_t slot);
    slot_cmd_t item;
    item.cmd = cmd;
    item.slot = slot;
    cmd_q.insert(cmd_q.size(), item);
  endtask

  // Bursts of one command kind with random slots, flushes and stray commands between
  task automatic queue_random(int n);
    int left;
    int len;
    int r;
    logic [CMD_W-1:0] c;
    left = n;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 42) c = CMD_ALLOC;
      else if (r < 80) c = CMD_FREE;
      else if (r < 95) c = CMD_FLUSH;
      else c = CMD_UNUSED;
      len = (c == CMD_ALLOC || c == CMD_FREE) ? $urandom_range(1, 8) : 1;
      repeat (len) begin
        if (left > 0) begin
          queue_cmd(c, idx_t'($urandom_range(0, POOL - 1)));
          left--;
        end
      end
    end
  endtask

  // Drain everything, then let a trailing flush walk finish
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_q.size() != 0 || s_tvalid || alloc_results_q.size() != 0) @(negedge clk);
    repeat (walk_len + 4) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_cfg = v;
    @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Zero limit: every fresh alloc exhausts, frees only count after a flush
    write_limit('0);
    queue_cmd(CMD_ALLOC, '0);
    queue_cmd(CMD_UNUSED, '1);
    queue_cmd(CMD_FREE, '1);
    queue_cmd(CMD_FREE, '0);
    queue_cmd(CMD_FREE, 11'h555);
    queue_cmd(CMD_FREE, 11'h2aa);
    queue_cmd(CMD_ALLOC, '0);
    queue_cmd(CMD_FLUSH, '1);
    repeat (5) queue_cmd(CMD_ALLOC, '1);
    queue_cmd(CMD_FLUSH, '0);
    queue_cmd(CMD_ALLOC, '1);
    wait_idle();

    write_limit(12'd1);
    queue_cmd(CMD_ALLOC, '0);
    queue_cmd(CMD_ALLOC, '0);
    queue_cmd(CMD_FREE, 11'd5);
    queue_cmd(CMD_FLUSH, '0);
    queue_cmd(CMD_ALLOC, '0);
    queue_cmd(CMD_ALLOC, '0);
    wait_idle();

    // Above the pool size: capped at the pool
    write_limit('1);
    queue_random(300);
    wait_idle();

    // Limit just ahead of the bump counter so exhaustion shows up often
    write_limit(LIMIT_W'(fresh_next + $urandom_range(0, 24)));
    queue_random(250);
    wait_idle();

    write_limit(LIMIT_W'($urandom_range(1, LIMIT_RESET)));
    queue_random(150);
    wait_idle();

    // Frees, a flush, then six allocs that pop the free stack and may run past it
    write_limit(LIMIT_W'(LIMIT_RESET));
    repeat (4) queue_cmd(CMD_FREE, idx_t'($urandom_range(0, POOL - 1)));
    queue_cmd(CMD_FLUSH, '0);
    repeat (6) queue_cmd(CMD_ALLOC, '0);
    wait_idle();

    repeat (64) @(posedge clk);
    if (alloc_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", alloc_results_q.size()));
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
